// ===== rtl/core/ovl_pkg.sv =====
// Package for the ordered value list: request and response structs,
// command and status codes. No dependencies.
package ovl_pkg;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
      logic signed [31:0] target;
      logic [6:0]         index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         entry_count;
      logic signed [31:0] read_value;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

endpackage

// ===== rtl/core/ordered_value_list_unit.sv =====
// Ordered value list top level: list memory with separate write and read ports, and its sequencer.
// Depends on ovl_pkg.
//
// Holds up to CAPACITY signed 32-bit values in one memory with one write and
// one registered read a cycle. A request is taken when start is high and busy
// is low; its single response appears on rsp_data for exactly one cycle with
// rsp_valid high and must be taken then, since the receiver cannot stall it.
// Append and rejected requests respond from the dispatch state, a read once
// its registered memory read is back. Insert and remove walk the memory once:
// a search through the entries up to the first match, then a shift of the
// entries behind it, one entry per cycle; an insert then writes its value
// after the match. A missing value ends the search with a not-found status.
// Busy stays high throughout.
// Entries are undefined until written; no clearing pass runs after reset.
module ordered_value_list_unit
   import ovl_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam int OW = (CW > 8) ? CW : 8;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_SEARCH   = 6'b000100,
      S_SHIFT    = 6'b001000,
      S_PLACE    = 6'b010000,
      S_RDWAIT   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      src_ff, src_in;
   logic [AW-1:0]      dst_ff, dst_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [31:0]        key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [31:0]        mem [CAPACITY];
   logic [31:0]        rdata_ff;
   logic               we, re;
   logic [AW-1:0]      waddr, raddr;
   logic [31:0]        wdata;

   logic               fin;
   logic [2:0]         fin_status;
   logic [31:0]        fin_rd;
   logic               issue;
   logic [CW-1:0]      pos_plus;
   logic [XW-1:0]      idx_ext;
   logic [XW-1:0]      count_ext;
   logic [OW-1:0]      count_out;

   assign pos_plus  = CW'(pos_ff) + CW'(1);
   assign idx_ext   = XW'(req_ff.index);
   assign count_ext = XW'(count_ff);
   assign count_out = OW'(count_in);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      pos_in       = pos_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rd_pend_in   = 1'b0;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = req_ff.value;
      re           = 1'b0;
      raddr        = '0;
      fin          = 1'b0;
      fin_status   = ST_OK;
      fin_rd       = '0;
      issue        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            scan_in = '0;
            unique case (req_ff.cmd)
               CMD_APPEND: begin
                  fin = 1'b1;
                  if (count_ff == CW'(CAPACITY)) begin
                     fin_status = ST_FULL;
                  end else begin
                     we       = 1'b1;
                     waddr    = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_INSERT: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     fin        = 1'b1;
                     fin_status = ST_FULL;
                  end else begin
                     key_in   = req_ff.target;
                     state_in = S_SEARCH;
                  end
               end
               CMD_REMOVE: begin
                  if (count_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                  end else begin
                     key_in   = req_ff.value;
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  if (idx_ext >= count_ext) begin
                     fin        = 1'b1;
                     fin_status = ST_RANGE;
                  end else begin
                     re       = 1'b1;
                     raddr    = idx_ext[AW-1:0];
                     state_in = S_RDWAIT;
                  end
               end
            endcase
         end
         S_SEARCH: begin
            // compare uses the data read in the cycle before
            if (rd_pend_ff && rdata_ff == key_ff) begin
               pos_in   = cmp_idx_ff;
               state_in = S_SHIFT;
               if (req_ff.cmd == CMD_INSERT) begin
                  src_in = count_ff - CW'(1);
               end else begin
                  src_in = CW'(cmp_idx_ff) + CW'(1);
               end
            end else if (scan_ff < count_ff) begin
               re         = 1'b1;
               raddr      = scan_ff[AW-1:0];
               rd_pend_in = 1'b1;
               cmp_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else begin
               fin        = 1'b1;
               fin_status = ST_NOT_FOUND;
            end
         end
         S_SHIFT: begin
            if (rd_pend_ff) begin
               we    = 1'b1;
               waddr = dst_ff;
               wdata = rdata_ff;
            end
            if (req_ff.cmd == CMD_INSERT) begin
               issue = src_ff > CW'(pos_ff);
            end else begin
               issue = src_ff < count_ff;
            end
            if (issue) begin
               re         = 1'b1;
               raddr      = src_ff[AW-1:0];
               rd_pend_in = 1'b1;
               if (req_ff.cmd == CMD_INSERT) begin
                  dst_in = AW'(src_ff + CW'(1));
                  src_in = src_ff - CW'(1);
               end else begin
                  dst_in = AW'(src_ff - CW'(1));
                  src_in = src_ff + CW'(1);
               end
            end else if (!rd_pend_ff) begin
               if (req_ff.cmd == CMD_INSERT) begin
                  state_in = S_PLACE;
               end else begin
                  count_in = count_ff - CW'(1);
                  fin      = 1'b1;
               end
            end
         end
         S_PLACE: begin
            we       = 1'b1;
            waddr    = pos_plus[AW-1:0];
            count_in = count_ff + CW'(1);
            fin      = 1'b1;
         end
         S_RDWAIT: begin
            fin    = 1'b1;
            fin_rd = rdata_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in           = S_IDLE;
         rsp_valid_in       = 1'b1;
         rsp_in.status      = fin_status;
         rsp_in.entry_count = count_out[7:0];
         rsp_in.read_value  = fin_rd;
         rsp_in.is_empty    = (count_in == '0);
         rsp_in.is_full     = (count_in == CW'(CAPACITY));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_ff     <= pos_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      key_ff     <= key_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (CW'(pos_ff) < count_ff))
      else $error("shift position beyond held entries");

endmodule

// ===== tb/ordered_value_list_unit_tb.sv =====
// Testbench for ordered_value_list_unit: directed and random list commands,
// each response checked against a queue-based model of the list.
// Depends on ovl_pkg and ordered_value_list_unit.
module ordered_value_list_unit_tb;
   import ovl_pkg::*;

   localparam int LIST_DEPTH = 128;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic signed [31:0] list_model_q[$];
   rsp_type            awaited_list_rsp_q[$];
   int unsigned        error_count = 0;
   bit                 gaps_on = 1'b1;

   ordered_value_list_unit #(
      .CAPACITY(LIST_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, exp);
      error_count++;
   endtask

   // Position of the first entry equal to key, -1 when absent.
   function automatic int find_entry(logic signed [31:0] key);
      for (int i = 0; i < list_model_q.size(); i++)
         if (list_model_q[i] == key) return i;
      return -1;
   endfunction

   function automatic rsp_type apply_list_command(req_type r);
      rsp_type res;
      int      pos;
      res = '0;
      res.status = ST_OK;
      case (r.cmd)
         CMD_APPEND: begin
            if (list_model_q.size() >= LIST_DEPTH) res.status = ST_FULL;
            else list_model_q.push_back(r.value);
         end
         CMD_INSERT: begin
            if (list_model_q.size() >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               pos = find_entry(r.target);
               if (pos < 0) res.status = ST_NOT_FOUND;
               else list_model_q.insert(pos + 1, r.value);
            end
         end
         CMD_REMOVE: begin
            if (list_model_q.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               pos = find_entry(r.value);
               if (pos < 0) res.status = ST_NOT_FOUND;
               else list_model_q.delete(pos);
            end
         end
         default: begin
            if (r.index >= list_model_q.size()) res.status = ST_RANGE;
            else res.read_value = list_model_q[r.index];
         end
      endcase
      res.entry_count = 8'(list_model_q.size());
      res.is_empty    = (list_model_q.size() == 0);
      res.is_full     = (list_model_q.size() >= LIST_DEPTH);
      return res;
   endfunction

   // Hold the request until the block takes it, then record what it must answer.
   task automatic issue_request(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_list_rsp_q.push_back(apply_list_command(r));
   endtask

   task automatic idle_gap();
      int unsigned n;
      int unsigned roll;
      if (!gaps_on) return;
      roll = $urandom_range(0, 99);
      if (roll < 45) n = 0;
      else if (roll < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(6, 40);
      if (n == 0) return;
      start    <= 1'b0;
      req_data <= '{cmd: 2'($urandom), value: $urandom, target: $urandom,
                    index: 7'($urandom)};
      repeat (n) @(posedge clock);
   endtask

   task automatic do_command(input logic [1:0] cmd, input logic signed [31:0] value,
                             input logic signed [31:0] target, input logic [6:0] index);
      issue_request('{cmd: cmd, value: value, target: target, index: index});
      idle_gap();
   endtask

   // Many small values so that duplicates and matches occur, some extremes, the rest random.
   function automatic logic signed [31:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 32'(int'($urandom_range(0, 16)) - 8);
      if (roll < 50) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic signed [31:0] pick_existing();
      return list_model_q[$urandom_range(0, list_model_q.size() - 1)];
   endfunction

   task automatic run_random_command(input logic [1:0] cmd);
      logic signed [31:0] value;
      logic signed [31:0] target;
      logic [6:0]         index;
      value  = pick_value();
      target = $urandom;
      index  = 7'($urandom);
      case (cmd)
         CMD_INSERT: begin
            if (list_model_q.size() > 0 && $urandom_range(0, 99) < 75)
               target = pick_existing();
            else
               target = pick_value();
         end
         CMD_REMOVE: begin
            if (list_model_q.size() > 0 && $urandom_range(0, 99) < 75)
               value = pick_existing();
         end
         CMD_READ: begin
            if (list_model_q.size() > 0 && $urandom_range(0, 99) < 80)
               index = 7'($urandom_range(0, list_model_q.size() - 1));
         end
         default: ;
      endcase
      do_command(cmd, value, target, index);
   endtask

   task automatic test_empty_list();
      do_command(CMD_READ, $urandom, $urandom, 7'd0);
      do_command(CMD_READ, $urandom, $urandom, 7'd127);
      do_command(CMD_REMOVE, 32'sd5, $urandom, 7'($urandom));
      do_command(CMD_INSERT, 32'sd9, 32'sd0, 7'($urandom));
   endtask

   task automatic test_edge_values();
      do_command(CMD_APPEND, 32'sh7fffffff, $urandom, 7'($urandom));
      do_command(CMD_APPEND, 32'sh80000000, $urandom, 7'($urandom));
      do_command(CMD_APPEND, 32'sd0, $urandom, 7'($urandom));
      do_command(CMD_APPEND, -32'sd1, $urandom, 7'($urandom));
      for (int i = 0; i < 4; i++) do_command(CMD_READ, $urandom, $urandom, 7'(i));
      // insert in the middle, after the last entry, and after a missing target
      do_command(CMD_INSERT, 32'sd42, 32'sh80000000, 7'($urandom));
      do_command(CMD_INSERT, 32'sd77, -32'sd1, 7'($urandom));
      do_command(CMD_INSERT, 32'sd13, 32'sd12345, 7'($urandom));
      do_command(CMD_APPEND, 32'sd0, $urandom, 7'($urandom));
      // the first of two equal entries goes
      do_command(CMD_REMOVE, 32'sd0, $urandom, 7'($urandom));
      do_command(CMD_REMOVE, 32'sd999, $urandom, 7'($urandom));
      do_command(CMD_READ, $urandom, $urandom, 7'd4);
      do_command(CMD_READ, $urandom, $urandom, 7'(list_model_q.size()));
      do_command(CMD_REMOVE, 32'sh7fffffff, $urandom, 7'($urandom));
      do_command(CMD_READ, $urandom, $urandom, 7'd0);
   endtask

   task automatic test_fill_and_drain();
      while (list_model_q.size() < LIST_DEPTH)
         run_random_command($urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT);
      do_command(CMD_APPEND, pick_value(), $urandom, 7'($urandom));
      do_command(CMD_INSERT, pick_value(), pick_existing(), 7'($urandom));
      do_command(CMD_INSERT, pick_value(), 32'sd424242, 7'($urandom));
      do_command(CMD_READ, $urandom, $urandom, 7'd127);
      do_command(CMD_READ, $urandom, $urandom, 7'd64);
      run_random_command(CMD_READ);
      while (list_model_q.size() > 0) run_random_command(CMD_REMOVE);
      do_command(CMD_READ, $urandom, $urandom, 7'd0);
   endtask

   task automatic test_random_mix();
      int unsigned roll;
      bit          grow;
      for (int phase = 0; phase < 8; phase++) begin
         gaps_on = (phase != 3 && phase != 6);
         grow    = (phase % 2 == 0);
         for (int k = 0; k < 125; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 35 : 15)) run_random_command(CMD_APPEND);
            else if (roll < (grow ? 65 : 30)) run_random_command(CMD_INSERT);
            else if (roll < 80) run_random_command(CMD_REMOVE);
            else run_random_command(CMD_READ);
         end
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin : check_responses
      rsp_type exp;
      if (!reset && rsp_valid) begin
         if (awaited_list_rsp_q.size() == 0) begin
            report_mismatch("response with none pending, status", rsp_data.status, -1);
         end else begin
            exp = awaited_list_rsp_q.pop_front();
            if (rsp_data.status !== exp.status)
               report_mismatch("status", rsp_data.status, exp.status);
            if (rsp_data.entry_count !== exp.entry_count)
               report_mismatch("entry_count", rsp_data.entry_count, exp.entry_count);
            if (rsp_data.read_value !== exp.read_value)
               report_mismatch("read_value", rsp_data.read_value, exp.read_value);
            if (rsp_data.is_empty !== exp.is_empty)
               report_mismatch("is_empty", rsp_data.is_empty, exp.is_empty);
            if (rsp_data.is_full !== exp.is_full)
               report_mismatch("is_full", rsp_data.is_full, exp.is_full);
         end
      end
   end

   initial begin
      int unsigned wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_edge_values();
      test_fill_and_drain();
      test_random_mix();
      start <= 1'b0;
      wait_cycles = 0;
      while (awaited_list_rsp_q.size() != 0 && wait_cycles < 4000) begin
         @(posedge clock);
         wait_cycles++;
      end
      // catch stray responses after the last one
      repeat (LIST_DEPTH + 10) @(posedge clock);
      if (awaited_list_rsp_q.size() != 0)
         report_mismatch("responses still pending", 0, awaited_list_rsp_q.size());
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
